[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication or expression, disabled in reset
`define LULS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression that never holds out of reset
`define LULS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

[sv/luls_pkg.sv]
// ----------------------------------------------------------------------------
// LU solver package
// Shared constants and types of the LU linear-system solver.
// ----------------------------------------------------------------------------
package luls_pkg;

    localparam int MAX_ORDER_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [4:0] MSIZE_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_SOLVE  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_FACT,
        PH_FWD,
        PH_BACK
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ELEM,
        ST_MAC_RD,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_FIN_RD,
        ST_FIN_DIFF,
        ST_FIN_DO,
        ST_DIV_WAIT,
        ST_NEXT,
        ST_DONE
    } t_state;

endpackage

[sv/luls_div.sv]
// ----------------------------------------------------------------------------
// LU solver divider
// Unsigned 64 by 32 bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module luls_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic [6:0]  r_cnt, n_cnt;
    logic        r_run, n_run;
    logic        r_done, n_done;
    logic [32:0] r_rem, n_rem;
    logic [63:0] r_q, n_q;
    logic [31:0] r_den, n_den;
    logic [32:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem[31:0], r_q[63]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_q    = r_q;
        n_den  = r_den;
        if (i_start) begin
            n_cnt = 7'd0;
            n_run = 1'b1;
            n_rem = 33'd0;
            n_q   = i_num;
            n_den = i_den;
        end else if (r_run) begin
            n_rem = fits ? rem_sh - {1'b0, r_den} : rem_sh;
            n_q   = {r_q[62:0], fits};
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

[sv/lu_linear_system_solver.sv]
// ----------------------------------------------------------------------------
// LU linear-system solver
// Loads A and B, factors A in place by Doolittle LU, solves AX = B in
// signed fixed point and returns X entries one word at a time.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+-------------------
//  command   | i_cmd i_row i_col i_value                 | start & !busy
//  result    | o_is_status o_zero_pivot o_saturated      | o_valid, 1 cycle
//            | o_result_value                            |
//  config    | i_cfg_data                                | i_cfg_valid & ready
//
//  Loads write from ST_IDLE; reads return through ST_READ. A solve runs on one
//  shared multiply-accumulate unit and one bit-serial divider: each product term
//  steps MAC_RD, MAC_MUL, MAC_ACC, and a division by a pivot waits in DIV_WAIT.
//  Reset is synchronous; the stores need no clearing. Results cannot stall.
// ----------------------------------------------------------------------------
module lu_linear_system_solver #(
    parameter int MAX_ORDER = luls_pkg::MAX_ORDER_DEF,
    parameter int FRAC_BITS = luls_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [3:0]         i_row,
    input  logic [3:0]         i_col,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic               o_is_status,
    output logic               o_zero_pivot,
    output logic               o_saturated,
    output logic signed [31:0] o_result_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [4:0]         i_cfg_data
);

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_ORDER);
    localparam int CW    = $clog2(MAX_ORDER + 1);
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] BIAS    = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(int'(r) * MAX_ORDER + int'(c));
    endfunction

    function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return {1'b1, (s[64] ? S64_MIN : S64_MAX)};
        return {1'b0, s[63:0]};
    endfunction

    function automatic logic [32:0] clip32(input logic signed [64:0] v);
        if (v > 65'sh0_7FFF_FFFF)
            return {1'b1, 32'h7FFF_FFFF};
        if (v < -65'sh0_8000_0000)
            return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    luls_pkg::t_state r_state, n_state;
    luls_pkg::t_phase r_phase;
    logic             div_start, div_done;

    logic [4:0]         r_msize;
    logic [CW-1:0]      n_eff, r_n;
    logic [CW-1:0]      r_i, r_j, r_k, r_kend;
    logic               r_use_div;
    logic               r_clip, r_pz;
    logic               r_rd_ok;
    logic signed [63:0] r_acc, r_prod, r_diff;
    logic signed [31:0] r_piv;

    logic signed [31:0] mem_f [DEPTH];
    logic signed [31:0] mem_b [DEPTH];
    logic signed [31:0] mem_x [DEPTH];
    logic signed [31:0] mem_y [MAX_ORDER];
    logic signed [31:0] r_fa_q, r_fb_q, r_rhs_q, r_x_q, r_y_q;

    logic [AW-1:0] fa_addr, fb_addr, rhs_addr, x_raddr, f_waddr, x_waddr;
    logic [IW-1:0] y_raddr;
    logic          f_we, x_we, y_we;
    logic signed [31:0] f_wdata, wr_val;
    logic          wr_clip;

    logic          accept, ld_ok, rd_ok;
    logic signed [31:0] op_b, entry;
    logic signed [63:0] prod, scaled, negacc;
    logic [64:0]   acc_sum, diff_sum;
    logic [32:0]   resc, quo_clip;
    logic signed [63:0] rs_num;
    logic [63:0]   num_mag, quo;
    logic [31:0]   den_mag;
    logic          quo_neg;
    logic signed [64:0] quo_s;
    logic          last_elem;

    assign accept = start && !busy;
    assign ld_ok  = (int'(i_row) < MAX_ORDER) && (int'(i_col) < MAX_ORDER);
    assign rd_ok  = (int'(i_row) < int'(n_eff)) && (int'(i_col) < int'(n_eff));

    always_comb begin
        if (r_msize == 5'd0)
            n_eff = CW'(1);
        else if (int'(r_msize) > MAX_ORDER)
            n_eff = CW'(MAX_ORDER);
        else
            n_eff = CW'(r_msize);
    end

    // arithmetic datapath
    always_comb begin
        unique case (r_phase)
            luls_pkg::PH_FACT: begin
                op_b  = r_fb_q;
                entry = r_fa_q;
            end
            luls_pkg::PH_FWD: begin
                op_b  = r_y_q;
                entry = r_rhs_q;
            end
            default: begin
                op_b  = r_x_q;
                entry = r_y_q;
            end
        endcase
    end

    assign prod     = r_fa_q * op_b;
    assign acc_sum  = sat_add(r_acc, r_prod);
    assign scaled   = 64'(entry) <<< FRAC_BITS;
    assign negacc   = (r_acc == S64_MIN) ? S64_MAX : -r_acc;
    assign diff_sum = sat_add(scaled, negacc);
    assign rs_num   = r_diff[63] ? r_diff + BIAS : r_diff;
    assign resc     = clip32(65'(rs_num >>> FRAC_BITS));
    assign num_mag  = r_diff[63] ? 64'(-r_diff) : 64'(r_diff);
    assign den_mag  = r_piv[31] ? 32'(-r_piv) : 32'(r_piv);
    assign quo_neg  = r_diff[63] ^ r_piv[31];
    assign quo_s    = quo_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign quo_clip = clip32(quo_s);

    luls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign last_elem = (r_phase == luls_pkg::PH_BACK) && (r_i == '0) && (r_j == r_n - CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            luls_pkg::ST_IDLE: begin
                if (accept && i_cmd == luls_pkg::CMD_SOLVE)
                    n_state = luls_pkg::ST_ELEM;
                else if (accept && i_cmd == luls_pkg::CMD_READ)
                    n_state = luls_pkg::ST_READ;
            end
            luls_pkg::ST_READ:     n_state = luls_pkg::ST_IDLE;
            luls_pkg::ST_ELEM:     n_state = luls_pkg::ST_MAC_RD;
            luls_pkg::ST_MAC_RD:
                n_state = (r_k == r_kend) ? luls_pkg::ST_FIN_RD : luls_pkg::ST_MAC_MUL;
            luls_pkg::ST_MAC_MUL:  n_state = luls_pkg::ST_MAC_ACC;
            luls_pkg::ST_MAC_ACC:  n_state = luls_pkg::ST_MAC_RD;
            luls_pkg::ST_FIN_RD:   n_state = luls_pkg::ST_FIN_DIFF;
            luls_pkg::ST_FIN_DIFF: n_state = luls_pkg::ST_FIN_DO;
            luls_pkg::ST_FIN_DO: begin
                if (r_use_div && r_piv != 32'sd0)
                    n_state = luls_pkg::ST_DIV_WAIT;
                else
                    n_state = luls_pkg::ST_NEXT;
            end
            luls_pkg::ST_DIV_WAIT: if (div_done) n_state = luls_pkg::ST_NEXT;
            luls_pkg::ST_NEXT:
                n_state = last_elem ? luls_pkg::ST_DONE : luls_pkg::ST_ELEM;
            luls_pkg::ST_DONE:     n_state = luls_pkg::ST_IDLE;
            default:               n_state = luls_pkg::ST_IDLE;
        endcase
    end

    // memory control and write data
    always_comb begin
        fa_addr  = (r_state == luls_pkg::ST_MAC_RD) ? addr_of(r_i, r_k) : addr_of(r_i, r_j);
        if (r_state == luls_pkg::ST_MAC_RD)
            fb_addr = addr_of(r_k, r_j);
        else if (r_phase == luls_pkg::PH_FACT)
            fb_addr = addr_of(r_j, r_j);
        else
            fb_addr = addr_of(r_i, r_i);
        rhs_addr = addr_of(r_i, r_j);
        y_raddr  = (r_state == luls_pkg::ST_MAC_RD) ? r_k[IW-1:0] : r_i[IW-1:0];
        x_raddr  = (r_state == luls_pkg::ST_IDLE) ? addr_of(CW'(i_row), CW'(i_col))
                                                  : addr_of(r_k, r_j);
        x_waddr  = addr_of(r_i, r_j);
        div_start = (r_state == luls_pkg::ST_FIN_DO) && r_use_div && (r_piv != 32'sd0);

        wr_val  = resc[31:0];
        wr_clip = resc[32];
        if (r_state == luls_pkg::ST_DIV_WAIT) begin
            wr_val  = quo_clip[31:0];
            wr_clip = quo_clip[32];
        end else if (r_use_div) begin
            wr_val  = 32'sd0;
            wr_clip = 1'b0;
        end
        x_we = 1'b0;
        y_we = 1'b0;
        f_we = 1'b0;
        if ((r_state == luls_pkg::ST_FIN_DO && !(r_use_div && r_piv != 32'sd0)) ||
            (r_state == luls_pkg::ST_DIV_WAIT && div_done)) begin
            unique case (r_phase)
                luls_pkg::PH_FACT: f_we = 1'b1;
                luls_pkg::PH_FWD:  y_we = 1'b1;
                default:           x_we = 1'b1;
            endcase
        end

        if (r_state == luls_pkg::ST_IDLE) begin
            f_waddr = addr_of(CW'(i_row), CW'(i_col));
            f_wdata = i_value;
            f_we    = accept && ld_ok && i_cmd == luls_pkg::CMD_LOAD_A;
        end else begin
            f_waddr = addr_of(r_i, r_j);
            f_wdata = wr_val;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (f_we)
            mem_f[f_waddr] <= f_wdata;
        r_fa_q <= mem_f[fa_addr];
        r_fb_q <= mem_f[fb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && ld_ok && i_cmd == luls_pkg::CMD_LOAD_B)
            mem_b[addr_of(CW'(i_row), CW'(i_col))] <= i_value;
        r_rhs_q <= mem_b[rhs_addr];
    end

    always_ff @(posedge i_clk) begin
        if (x_we)
            mem_x[x_waddr] <= wr_val;
        r_x_q <= mem_x[x_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (y_we)
            mem_y[r_i[IW-1:0]] <= wr_val;
        r_y_q <= mem_y[y_raddr];
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= luls_pkg::ST_IDLE;
            r_phase      <= luls_pkg::PH_FACT;
            r_msize      <= luls_pkg::MSIZE_RESET;
            r_clip       <= 1'b0;
            r_pz         <= 1'b0;
            o_valid      <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_kend       <= '0;
            r_n          <= CW'(1);
            r_use_div    <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready)
                r_msize <= i_cfg_data;
            unique case (r_state)
                luls_pkg::ST_IDLE: begin
                    r_rd_ok <= rd_ok;
                    if (accept && i_cmd == luls_pkg::CMD_SOLVE) begin
                        r_phase <= luls_pkg::PH_FACT;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_n     <= n_eff;
                        r_clip  <= 1'b0;
                        r_pz    <= 1'b0;
                    end
                end
                luls_pkg::ST_READ: begin
                    o_valid        <= 1'b1;
                    o_is_status    <= 1'b0;
                    o_result_value <= r_rd_ok ? r_x_q : 32'sd0;
                end
                luls_pkg::ST_ELEM: begin
                    r_acc <= '0;
                    unique case (r_phase)
                        luls_pkg::PH_FACT: begin
                            r_k       <= '0;
                            r_kend    <= (r_i <= r_j) ? r_i : r_j;
                            r_use_div <= r_i > r_j;
                        end
                        luls_pkg::PH_FWD: begin
                            r_k       <= '0;
                            r_kend    <= r_i;
                            r_use_div <= 1'b0;
                        end
                        default: begin
                            r_k       <= r_i + CW'(1);
                            r_kend    <= r_n;
                            r_use_div <= 1'b1;
                        end
                    endcase
                end
                luls_pkg::ST_MAC_MUL: r_prod <= prod;
                luls_pkg::ST_MAC_ACC: begin
                    r_acc <= acc_sum[63:0];
                    r_k   <= r_k + CW'(1);
                    if (acc_sum[64])
                        r_clip <= 1'b1;
                end
                luls_pkg::ST_FIN_DIFF: begin
                    r_diff <= diff_sum[63:0];
                    r_piv  <= r_fb_q;
                    if (diff_sum[64] || r_acc == S64_MIN)
                        r_clip <= 1'b1;
                end
                luls_pkg::ST_FIN_DO: begin
                    if (r_use_div && r_piv == 32'sd0)
                        r_pz <= 1'b1;
                    else if (!r_use_div && wr_clip)
                        r_clip <= 1'b1;
                end
                luls_pkg::ST_DIV_WAIT: begin
                    if (div_done && wr_clip)
                        r_clip <= 1'b1;
                end
                luls_pkg::ST_NEXT: begin
                    unique case (r_phase)
                        luls_pkg::PH_FACT: begin
                            if (r_i == r_n - CW'(1)) begin
                                r_i <= '0;
                                if (r_j == r_n - CW'(1)) begin
                                    r_j     <= '0;
                                    r_phase <= luls_pkg::PH_FWD;
                                end else begin
                                    r_j <= r_j + CW'(1);
                                end
                            end else begin
                                r_i <= r_i + CW'(1);
                            end
                        end
                        luls_pkg::PH_FWD: begin
                            if (r_i == r_n - CW'(1))
                                r_phase <= luls_pkg::PH_BACK;
                            else
                                r_i <= r_i + CW'(1);
                        end
                        default: begin
                            if (r_i == '0) begin
                                if (!last_elem) begin
                                    r_j     <= r_j + CW'(1);
                                    r_phase <= luls_pkg::PH_FWD;
                                end
                            end else begin
                                r_i <= r_i - CW'(1);
                            end
                        end
                    endcase
                end
                luls_pkg::ST_DONE: begin
                    o_valid        <= 1'b1;
                    o_is_status    <= 1'b1;
                    o_result_value <= 32'sd0;
                end
                default: ;
            endcase
        end
    end

    assign busy         = r_state != luls_pkg::ST_IDLE;
    assign o_cfg_ready  = !busy;
    assign o_zero_pivot = r_pz;
    assign o_saturated  = r_clip;

`include "assert_macros.svh"

    `LULS_ASSERT(a_solve_busy, accept && i_cmd == luls_pkg::CMD_SOLVE |=> busy, "solve not started")
    `LULS_ASSERT(a_one_strobe, o_valid |=> !o_valid, "result strobe longer than one cycle")
    `LULS_NEVER(a_div_zero, r_state == luls_pkg::ST_DIV_WAIT && r_piv == 32'sd0, "divide by zero pivot")
    `LULS_ASSERT(a_status_val, o_valid && o_is_status |-> o_result_value == 32'sd0, "status word nonzero")

endmodule
